[sv/wsc_pkg.sv]
`timescale 1ns / 1ps

package wsc_pkg;

    localparam int MAX_PATTERNS_DEF    = 512;
    localparam int MAX_PATTERN_LEN_DEF = 16;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_WORD    = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] word_ways;
        logic [63:0] total_ways;
        logic        overflow;
        logic        dictionary_full;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

[sv/word_segmentation_counter_core.sv]
`timescale 1ns / 1ps

// channel   ports                            moves
// s_        s_valid s_ready s_item           clear / pattern symbol / word symbol
// m_        m_valid m_ready m_item           word count, running total, flags
//
// clear and pattern symbols leave the core idle, ready for the next item
// a word symbol scans the dictionary: one stored pattern per cycle is read
// from the pattern memory (one write port, one read port) and summed in one
// shared saturating 64-bit adder, which also forms the running total
// a word's final symbol waits in the finish step while the result register is full
// synchronous active-low reset empties the dictionary, total, flags and window

module word_segmentation_counter_core #(
    parameter int MAX_PATTERNS    = wsc_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = wsc_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wsc_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output wsc_pkg::out_item_t m_item
);

    localparam int L  = MAX_PATTERN_LEN;
    localparam int RW = L * 8;
    localparam int LW = $clog2(L + 1);
    localparam int PW = $clog2(L + 2);
    localparam int CW = $clog2(MAX_PATTERNS + 1);
    localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int DW = RW + LW;

    wsc_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [RW-1:0]      load_row_reg, load_row_next;
    logic [7:0]         recent_reg [L];
    logic [7:0]         recent_next [L];
    logic [63:0]        window_reg [L+1];
    logic [63:0]        window_next [L+1];
    logic [63:0]        total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               dfull_reg, dfull_next;
    logic [63:0]        acc_reg, acc_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               last_reg, last_next;
    logic               m_valid_reg, m_valid_next;
    wsc_pkg::out_item_t m_item_reg, m_item_next;

    logic               accept;
    logic [RW+7:0]      load_shift;
    logic [PW-1:0]      pos_inc;
    logic               wr_en;
    logic [DW-1:0]      wr_data;
    logic               rd_en;
    logic [DW-1:0]      rd_data;
    logic               rd_valid;
    logic               add_valid;
    logic [63:0]        addend;
    logic [63:0]        add_a, add_b;
    logic [64:0]        sum65;
    logic [63:0]        sat_sum;
    logic               sat_carry;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == wsc_pkg::ST_IDLE);

    wsc_pattern_mem #(
        .DEPTH (MAX_PATTERNS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (count_reg[AW-1:0]),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (ptr_reg[AW-1:0]),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    wsc_match #(
        .L  (L),
        .LW (LW)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_valid  (rd_valid),
        .rd_row    (rd_data[RW-1:0]),
        .rd_len    (rd_data[DW-1:RW]),
        .recent    (recent_reg),
        .window    (window_reg),
        .add_valid (add_valid),
        .addend    (addend)
    );

    // shared saturating adder: partial sums in scan/drain, running total at the end
    always_comb begin
        if (state_reg == wsc_pkg::ST_FINISH) begin
            add_a = total_reg;
            add_b = acc_reg;
        end else begin
            add_a = acc_reg;
            add_b = addend;
        end
        sum65     = {1'b0, add_a} + {1'b0, add_b};
        sat_carry = sum65[64];
        sat_sum   = sat_carry ? {64{1'b1}} : sum65[63:0];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        load_row_next = load_row_reg;
        recent_next   = recent_reg;
        window_next   = window_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        dfull_next    = dfull_reg;
        acc_next      = acc_reg;
        ptr_next      = ptr_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        // new pattern symbol lands in byte 0, older ones move up
        load_shift = {load_row_reg, s_item.symbol};
        pos_inc    = pos_reg + PW'(1);
        wr_data    = {pos_inc[LW-1:0], load_shift[RW-1:0]};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (add_valid) begin
            acc_next = sat_sum;
            if (sat_carry) begin
                ovf_next = 1'b1;
            end
        end

        case (state_reg)
            wsc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_item.action)
                        wsc_pkg::ACT_CLEAR: begin
                            count_next = '0;
                            pos_next   = '0;
                            total_next = '0;
                            ovf_next   = 1'b0;
                            dfull_next = 1'b0;
                            for (int k = 0; k < L; k++) begin
                                recent_next[k] = 8'd0;
                            end
                            for (int k = 0; k <= L; k++) begin
                                window_next[k] = (k == 0) ? 64'd1 : 64'd0;
                            end
                        end
                        wsc_pkg::ACT_PATTERN: begin
                            load_row_next = load_shift[RW-1:0];
                            if (pos_reg <= PW'(L)) begin
                                pos_next = pos_inc;
                            end
                            if (s_item.last) begin
                                if (pos_reg < PW'(L) && count_reg < CW'(MAX_PATTERNS)) begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end else begin
                                    dfull_next = 1'b1;
                                end
                                pos_next = '0;
                            end
                        end
                        wsc_pkg::ACT_WORD: begin
                            for (int k = L - 1; k > 0; k--) begin
                                recent_next[k] = recent_reg[k-1];
                            end
                            recent_next[0] = s_item.symbol;
                            acc_next       = '0;
                            ptr_next       = '0;
                            last_next      = s_item.last;
                            state_next     = wsc_pkg::ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wsc_pkg::ST_SCAN: begin
                if (ptr_reg == count_reg) begin
                    state_next = wsc_pkg::ST_DRAIN;
                end else begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            wsc_pkg::ST_DRAIN: begin
                if (!rd_valid && !add_valid) begin
                    state_next = wsc_pkg::ST_FINISH;
                end
            end
            wsc_pkg::ST_FINISH: begin
                if (!last_reg) begin
                    for (int k = L; k > 0; k--) begin
                        window_next[k] = window_reg[k-1];
                    end
                    window_next[0] = acc_reg;
                    state_next     = wsc_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    total_next                  = sat_sum;
                    ovf_next                    = ovf_reg | sat_carry;
                    m_valid_next                = 1'b1;
                    m_item_next.word_ways       = acc_reg;
                    m_item_next.total_ways      = sat_sum;
                    m_item_next.overflow        = ovf_reg | sat_carry;
                    m_item_next.dictionary_full = dfull_reg;
                    for (int k = 0; k < L; k++) begin
                        recent_next[k] = 8'd0;
                    end
                    for (int k = 0; k <= L; k++) begin
                        window_next[k] = (k == 0) ? 64'd1 : 64'd0;
                    end
                    state_next = wsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wsc_pkg::ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            dfull_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < L; k++) begin
                recent_reg[k] <= 8'd0;
            end
            for (int k = 0; k <= L; k++) begin
                window_reg[k] <= (k == 0) ? 64'd1 : 64'd0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            dfull_reg   <= dfull_next;
            m_valid_reg <= m_valid_next;
            recent_reg  <= recent_next;
            window_reg  <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        load_row_reg <= load_row_next;
        acc_reg      <= acc_next;
        ptr_reg      <= ptr_next;
        last_reg     <= last_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == wsc_pkg::ST_FINISH))
        else $error("result appeared outside the finish step");

    a_total_covers_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_item_reg.total_ways >= m_item_reg.word_ways)
        else $error("running total below word count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PATTERNS))
        else $error("pattern count beyond store size");

    a_scan_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wsc_pkg::ST_SCAN |-> ptr_reg <= count_reg)
        else $error("scan pointer ran past stored patterns");

    a_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wsc_pkg::ST_IDLE || state_reg == wsc_pkg::ST_FINISH)
            |-> !rd_valid && !add_valid)
        else $error("match pipeline busy outside scan");

endmodule

[sv/wsc_pattern_mem.sv]
`timescale 1ns / 1ps

module wsc_pattern_mem #(
    parameter int DEPTH = wsc_pkg::MAX_PATTERNS_DEF,
    parameter int AW    = 9,
    parameter int DW    = 133
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    output logic          rd_valid
);

    logic [DW-1:0] pat_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic          rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= pat_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

[sv/wsc_match.sv]
`timescale 1ns / 1ps

module wsc_match #(
    parameter int L  = wsc_pkg::MAX_PATTERN_LEN_DEF,
    parameter int LW = $clog2(L + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_valid,
    input  logic [L*8-1:0]  rd_row,
    input  logic [LW-1:0]   rd_len,
    input  logic [7:0]      recent [L],
    input  logic [63:0]     window [L+1],
    output logic            add_valid,
    output logic [63:0]     addend
);

    logic          hit;
    logic [LW-1:0] win_idx;
    logic          add_valid_reg;
    logic [63:0]   addend_reg;

    // byte j of a stored row is the pattern symbol that lines up with recent[j]
    always_comb begin
        hit = 1'b1;
        for (int j = 0; j < L; j++) begin
            if (j < int'(rd_len) && rd_row[j*8 +: 8] != recent[j]) begin
                hit = 1'b0;
            end
        end
        win_idx = rd_len - LW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_valid_reg <= 1'b0;
        end else begin
            add_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        addend_reg <= hit ? window[win_idx] : 64'd0;
    end

    assign add_valid = add_valid_reg;
    assign addend    = addend_reg;

endmodule
